### hdl/tsp_pkg.sv
package tsp_pkg;

    // Fixed geometry of the move, in 24.8 counts.
    localparam logic [31:0] START_OFFSET     = 32'd256000;
    localparam logic [31:0] FINISH_TOLERANCE = 32'd5120;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECEL_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_SPEED    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_SPEED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_LENGTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_MOVE = 3'd5;
    localparam int unsigned CFG_DATA_W = 24;

    // Phase codes reported with each result.
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_RUN   = 2'd1;
    localparam logic [1:0] PHASE_DECEL = 2'd2;
    localparam logic [1:0] PHASE_BRAKE = 2'd3;

    // Item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Divider geometry: magnitude of speed^2 - exit^2 over the remaining distance.
    localparam int unsigned DIVIDEND_W = 31;
    localparam int unsigned DIVISOR_W  = 33;

    typedef struct packed {
        logic              kind;
        logic              brake;
        logic signed [7:0] left_count;
        logic signed [7:0] right_count;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] speed_out;
        logic signed [31:0] position_out;
        logic signed [15:0] required_decel;
        logic [1:0]         phase;
        logic               move_done;
    } out_word_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/tsp_div.sv
module tsp_div
    import tsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;
    logic                  fits;

    // One restoring step per cycle: the dividend shifts out of the top of
    // quo_reg while quotient bits shift in at the bottom.
    assign trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/trapezoidal_speed_profiler.sv
// Straight-move trapezoidal speed profiler.
// Input channel (in_valid, in_stall, in_word): a start word begins a move at
// the fixed start offset with the configured length; a tick word in a move
// ramps the speed, advances the position by the mean of the two encoder
// counts and, unless braking, checks the decel needed to reach exit speed.
// Output channel (out_valid, out_stall, out_word): exactly one result word per
// input word, in order. The result sits in an output register and holds while
// out_stall is high; the next input word can be accepted meanwhile.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while the block is idle. Unknown indexes are ignored.
// Sequence: a start word, an idle tick, a finishing tick or a brake tick goes
// from IDLE through EVAL to WRITE. A ramp tick goes through EVAL, SQS, SQE,
// DIV, APPLY and WRITE; in DIV it runs a 31-step restoring divider, one
// quotient bit per cycle. WRITE waits while the output register is stalled,
// and out_valid rises once WRITE hands the result over. in_stall is high
// from acceptance until then, so a new word is taken only after that.
// Reset clears the configuration registers, the move state and the output valid.
module trapezoidal_speed_profiler
    import tsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_SQS   = 7'b0000100,
        ST_SQE   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_APPLY = 7'b0100000,
        ST_WRITE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  accel_reg;
    logic [7:0]  decel_reg;
    logic [14:0] top_reg;
    logic [14:0] exit_reg;
    logic [23:0] len_reg;
    logic        rev_reg;

    // Move state.
    logic signed [15:0] speed_reg, speed_next;
    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        tgt_reg, tgt_next;
    logic               active_reg, active_next;
    logic signed [15:0] decel_last_reg, decel_last_next;

    // Working registers for one item.
    in_word_t    item_reg, item_next;
    logic [1:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [30:0] sq_reg, sq_next;
    logic        neg_reg, neg_next;

    // Output register.
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    // Shared datapath signals.
    logic signed [33:0] pos_x, tgt_x, dist_x;
    logic               at_end;
    logic signed [17:0] spd_x, acc_x, dec_x, top_x, exit_x, dreq_x;
    logic signed [17:0] ramp_sum;
    logic signed [15:0] brake_speed, ramp_speed, apply_speed;
    logic signed [8:0]  count_sum;
    logic [31:0]        advance;
    logic signed [15:0] mul_op;
    logic signed [31:0] mul_prod;
    logic signed [31:0] numer;
    logic [31:0]        numer_mag;
    logic [30:0]        half_mag;
    logic signed [15:0] dreq;
    logic               out_free;
    div_req_t           dreq_bus;
    div_rsp_t           drsp_bus;

    tsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq_bus),
        .rsp   (drsp_bus)
    );

    // End test and remaining distance, widened so that nothing wraps.
    assign pos_x  = {{2{pos_reg[31]}}, pos_reg};
    assign tgt_x  = {{2{tgt_reg[31]}}, tgt_reg};
    assign dist_x = tgt_x - pos_x;
    assign at_end = (pos_x >= (tgt_x - $signed({2'b00, FINISH_TOLERANCE})));

    assign spd_x  = {{2{speed_reg[15]}}, speed_reg};
    assign acc_x  = {10'd0, accel_reg};
    assign dec_x  = {10'd0, decel_reg};
    assign top_x  = {3'd0, top_reg};
    assign exit_x = {3'd0, exit_reg};
    assign dreq_x = {{2{decel_last_reg[15]}}, decel_last_reg};

    // Brake ramp toward zero, plain ramp toward the signed top speed, and the
    // deceleration clamp at the exit speed. All results fit in 16 bits.
    always_comb
    begin
        if (!rev_reg)
        begin
            ramp_sum    = spd_x - dec_x;
            brake_speed = (ramp_sum <= 18'sd0) ? 16'sd0 : ramp_sum[15:0];
        end
        else
        begin
            ramp_sum    = spd_x + acc_x;
            brake_speed = (ramp_sum >= 18'sd0) ? 16'sd0 : ramp_sum[15:0];
        end
    end

    always_comb
    begin
        logic signed [17:0] t;
        if (!rev_reg)
        begin
            t          = spd_x + acc_x;
            ramp_speed = (t >= top_x) ? {1'b0, top_reg} : t[15:0];
        end
        else
        begin
            t          = spd_x - dec_x;
            ramp_speed = (t <= -top_x) ? 16'(-top_x) : t[15:0];
        end
    end

    always_comb
    begin
        logic signed [17:0] t;
        if (!rev_reg)
        begin
            t           = spd_x - dreq_x;
            apply_speed = (t <= exit_x) ? {1'b0, exit_reg} : t[15:0];
        end
        else
        begin
            t           = spd_x + dreq_x;
            apply_speed = (t >= exit_x) ? {1'b0, exit_reg} : t[15:0];
        end
    end

    // Position advance: mean of the two counts times 256 is their sum times 128.
    assign count_sum = {item_reg.left_count[7], item_reg.left_count}
                     + {item_reg.right_count[7], item_reg.right_count};
    assign advance   = {{16{count_sum[8]}}, count_sum, 7'd0};

    // One multiplier squares the speed, then the exit speed, on successive cycles.
    assign mul_op    = (state_reg == ST_SQS) ? speed_reg : {1'b0, exit_reg};
    assign mul_prod  = mul_op * mul_op;
    assign numer     = $signed({1'b0, sq_reg}) - mul_prod;
    assign numer_mag = numer[31] ? 32'(-numer) : numer;

    assign dreq_bus.start    = (state_reg == ST_SQE);
    assign dreq_bus.dividend = numer_mag[30:0];
    assign dreq_bus.divisor  = dist_x[32:0];

    // Halve the quotient magnitude (truncation toward zero) and saturate.
    assign half_mag = {1'b0, drsp_bus.quotient[30:1]};
    always_comb
    begin
        if (neg_reg)
            dreq = (half_mag > 31'd32768) ? 16'sh8000 : 16'(-half_mag);
        else
            dreq = (half_mag > 31'd32767) ? 16'sd32767 : half_mag[15:0];
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        speed_next      = speed_reg;
        pos_next        = pos_reg;
        tgt_next        = tgt_reg;
        active_next     = active_reg;
        decel_last_next = decel_last_reg;
        item_next       = item_reg;
        phase_next      = phase_reg;
        done_next       = done_reg;
        sq_next         = sq_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_word;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                phase_next = PHASE_IDLE;
                done_next  = 1'b0;
                state_next = ST_WRITE;
                if (item_reg.kind == KIND_START)
                begin
                    pos_next    = START_OFFSET;
                    tgt_next    = START_OFFSET + {8'd0, len_reg};
                    active_next = 1'b1;
                    phase_next  = PHASE_RUN;
                end
                else if (active_reg)
                begin
                    if (at_end)
                    begin
                        // The move is over: position holds, speed carries on.
                        active_next = 1'b0;
                        tgt_next    = '0;
                        done_next   = 1'b1;
                    end
                    else if (item_reg.brake)
                    begin
                        speed_next = brake_speed;
                        phase_next = PHASE_BRAKE;
                        pos_next   = pos_reg + advance;
                    end
                    else
                    begin
                        speed_next = ramp_speed;
                        phase_next = PHASE_RUN;
                        state_next = ST_SQS;
                    end
                end
            end
            ST_SQS:
            begin
                sq_next    = mul_prod[30:0];
                state_next = ST_SQE;
            end
            ST_SQE:
            begin
                neg_next   = numer[31];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drsp_bus.done)
                begin
                    decel_last_next = dreq;
                    state_next      = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (decel_last_reg >= $signed({8'd0, rev_reg ? accel_reg : decel_reg}))
                begin
                    phase_next = PHASE_DECEL;
                    speed_next = apply_speed;
                end
                pos_next   = pos_reg + advance;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.speed_out      = speed_reg;
                    out_word_next.position_out   = pos_reg;
                    out_word_next.required_decel = decel_last_reg;
                    out_word_next.phase          = phase_reg;
                    out_word_next.move_done      = done_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            speed_reg      <= '0;
            pos_reg        <= '0;
            tgt_reg        <= '0;
            active_reg     <= 1'b0;
            decel_last_reg <= '0;
            out_valid_reg  <= 1'b0;
            accel_reg      <= '0;
            decel_reg      <= '0;
            top_reg        <= '0;
            exit_reg       <= '0;
            len_reg        <= '0;
            rev_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            speed_reg      <= speed_next;
            pos_reg        <= pos_next;
            tgt_reg        <= tgt_next;
            active_reg     <= active_next;
            decel_last_reg <= decel_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ACCEL_STEP:   accel_reg <= cfg_data[7:0];
                    CFG_DECEL_STEP:   decel_reg <= cfg_data[7:0];
                    CFG_TOP_SPEED:    top_reg   <= cfg_data[14:0];
                    CFG_EXIT_SPEED:   exit_reg  <= cfg_data[14:0];
                    CFG_MOVE_LENGTH:  len_reg   <= cfg_data[23:0];
                    CFG_REVERSE_MOVE: rev_reg   <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        phase_reg    <= phase_next;
        done_reg     <= done_next;
        sq_reg       <= sq_next;
        neg_reg      <= neg_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

endmodule
